// ===== hw/rtl/fdta_pkg.sv =====
// package: shared types, constants and helpers of the fractional delay block
package fdta_pkg;

  // store depth, a power of two so the pointers wrap by truncation
  localparam int STORE_DEPTH = 128;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int DELAY_W    = 7;
  localparam int COEF_BITS  = 16;
  localparam int FRAC_BITS  = COEF_BITS - 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // product, feed-forward sum (four terms) and full sum (seven terms)
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int FF_W   = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RND_W  = ACC_W - FRAC_BITS;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WHOLE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE  = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_word_t;
  typedef logic [ADDR_W-1:0]             addr_t;

  typedef struct packed {
    coef_word_t c1;
    coef_word_t c2;
    coef_word_t c3;
  } coef_t;

  // whole delay modulo the store depth
  function automatic addr_t dly_mod(input logic [DELAY_W-1:0] d);
    logic [ADDR_W+DELAY_W-1:0] ext;
    ext = {{ADDR_W{1'b0}}, d};
    return ext[ADDR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/fdta_if.sv =====
// interfaces: sample input, sample output and configuration write channels
interface fdta_in_if;
  import fdta_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fdta_out_if;
  import fdta_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface fdta_cfg_if;
  import fdta_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/fractional_delay_thiran_allpass_top.sv =====
// top level: fractional delay line with third-order thiran allpass
//
// channels: in_i takes one signed sample per beat, out_o gives one delayed,
// filtered sample per beat, cfg_i writes the four registers (whole delay
// and the three allpass coefficients) by index; cfg_i is always ready
// path: a sample accepted on in_i passes the store read register, the
// feed-forward register and the output register before it shows on out_o
// throughput: one sample per cycle while out_o is ready; the feedback
// stage closes the recursion with three parallel multiplies and a subtract
// reset: config, valid and history registers clear to zero, the write
// pointer goes to the last store entry, per-entry valid bits make the whole
// store read as zero at once: no clearing pass, in_i ready right after reset
// stall: each stage holds while the next one is full and held, so a waiting
// result on out_o does not block new beats until all stages are occupied
// the store depth must be a power of two
module fractional_delay_thiran_allpass_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  fdta_in_if.sink   in_i,
  fdta_out_if.source out_o,
  fdta_cfg_if.sink  cfg_i
);
  import fdta_pkg::*;

  // configuration registers
  logic [DELAY_W-1:0] whole_delay_q;
  coef_t              coef_q;

  // sample store and its per-entry valid bits
  sample_t                mem_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  addr_t                  wp_q;
  addr_t                  rp;
  logic                   zero_dly;

  // stage one: registered store read plus bypass for zero delay
  logic    v1_q;
  sample_t rd_q;
  sample_t byp_q;
  logic    byp_sel_q;
  logic    hit_q;
  sample_t x;

  logic in_acc, en1, x_ready;

  assign zero_dly = (dly_mod(whole_delay_q) == '0);
  assign rp       = wp_q - dly_mod(whole_delay_q);
  assign en1      = !v1_q || x_ready;
  assign in_acc   = in_i.valid && en1;
  assign in_i.ready = en1;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_delay_q <= '0;
      coef_q        <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WHOLE_DELAY: whole_delay_q <= cfg_i.data[DELAY_W-1:0];
        REG_COEF_ONE:    coef_q.c1     <= cfg_i.data;
        REG_COEF_TWO:    coef_q.c2     <= cfg_i.data;
        REG_COEF_THREE:  coef_q.c3     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // control: write pointer, valid bits, stage one occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= addr_t'(STORE_DEPTH - 1);
      vld_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_i.valid;
      end
      if (in_acc) begin
        vld_q[wp_q] <= 1'b1;
        wp_q        <= (wp_q == addr_t'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
    end
  end

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_q[wp_q] <= in_i.sample_in;
    end
    if (in_acc) begin
      rd_q      <= mem_q[rp];
      byp_q     <= in_i.sample_in;
      byp_sel_q <= zero_dly;
      hit_q     <= vld_q[rp];
    end
  end

  // an entry never written reads as zero
  assign x = byp_sel_q ? byp_q : (hit_q ? rd_q : '0);

  fdta_allpass u_allpass (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .coef_i    (coef_q),
    .x_valid_i (v1_q),
    .x_i       (x),
    .x_ready_o (x_ready),
    .out_o     (out_o)
  );

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q)
    else $error("accepted beat did not reach stage one");
  a_wp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> wp_q == addr_t'($past(wp_q) + 1'b1))
    else $error("write pointer did not advance by one");
  a_wp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(wp_q) && $stable(vld_q))
    else $error("store state changed without an accepted beat");
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !x_ready |=> v1_q && $stable(x))
    else $error("stage one sample changed while stalled");

endmodule

// ===== hw/rtl/fdta_allpass.sv =====
// third-order allpass: feed-forward stage, feedback stage and output register
module fdta_allpass (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fdta_pkg::coef_t coef_i,
  input  logic            x_valid_i,
  input  fdta_pkg::sample_t x_i,
  output logic            x_ready_o,
  fdta_out_if.source      out_o
);
  import fdta_pkg::*;

  localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // past inputs and outputs, index 2 newest
  sample_t xh_q [3];
  sample_t yh_q [3];

  logic                   v2_q, v3_q;
  logic signed [FF_W-1:0] ff_q;
  sample_t                out_q;

  logic en2, en3;
  logic signed [PROD_W-1:0] pf1, pf2, pf3, pb1, pb2, pb3;
  logic signed [FF_W-1:0]   ff_d;
  logic signed [ACC_W-1:0]  acc, acc_r;
  logic signed [RND_W-1:0]  rnd;
  sample_t                  y;

  assign en3       = !v3_q || out_o.ready;
  assign en2       = !v2_q || en3;
  assign x_ready_o = en2;

  // feed-forward part: x[n-3] scaled plus three products
  assign pf1  = xh_q[1] * coef_i.c1;
  assign pf2  = xh_q[2] * coef_i.c2;
  assign pf3  = x_i * coef_i.c3;
  assign ff_d = FF_W'($signed({xh_q[0], {FRAC_BITS{1'b0}}})) + FF_W'(pf1)
              + FF_W'(pf2) + FF_W'(pf3);

  // feedback part from past outputs
  assign pb1   = yh_q[2] * coef_i.c1;
  assign pb2   = yh_q[1] * coef_i.c2;
  assign pb3   = yh_q[0] * coef_i.c3;
  assign acc   = ACC_W'(ff_q) - ACC_W'(pb1) - ACC_W'(pb2) - ACC_W'(pb3);
  assign acc_r = acc + ACC_W'(1 << (FRAC_BITS - 1));
  assign rnd   = acc_r[ACC_W-1:FRAC_BITS];

  always_comb begin
    if (rnd > RND_W'(SMP_MAX)) begin
      y = SMP_MAX;
    end else if (rnd < RND_W'(SMP_MIN)) begin
      y = SMP_MIN;
    end else begin
      y = rnd[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else begin
      if (en2) begin
        v2_q <= x_valid_i;
        if (x_valid_i) begin
          xh_q[0] <= xh_q[1];
          xh_q[1] <= xh_q[2];
          xh_q[2] <= x_i;
        end
      end
      if (en3) begin
        v3_q <= v2_q;
        if (v2_q) begin
          yh_q[0] <= yh_q[1];
          yh_q[1] <= yh_q[2];
          yh_q[2] <= y;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && x_valid_i) begin
      ff_q <= ff_d;
    end
    if (en3 && v2_q) begin
      out_q <= y;
    end
  end

  assign out_o.valid      = v3_q;
  assign out_o.sample_out = out_q;

  a_fb_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && en3 |=> v3_q && out_o.sample_out == yh_q[2])
    else $error("output beat does not match newest past output");
  a_ff_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en3 |=> v2_q && $stable(ff_q) && $stable(xh_q[2]))
    else $error("feed-forward stage lost its sample while stalled");
  a_yh_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v2_q && en3) |=> $stable(yh_q[2]) && $stable(yh_q[0]))
    else $error("past outputs moved without a result");

endmodule
